### hdl/ltsi_pkg.sv
// Shared types, constants and tables for the stick-breaking simplex transform.
package ltsi_pkg;

  localparam int SIMPLEX_SIZE = 16;

  localparam logic [7:0]  LAST_POS  = 8'(SIMPLEX_SIZE - 2);
  localparam logic [7:0]  M_TOP     = 8'(SIMPLEX_SIZE - 1);
  localparam logic [39:0] LN2_Q30   = 40'd744261118;
  // Reciprocal floor(2^46 / LN2_Q30) for the range reduction estimate.
  localparam logic [16:0] INV_LN2_Q46 = 17'd94548;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic signed [32:0] ONE_Q31 = 33'sh0_8000_0000;
  localparam logic [3:0]  EXP_TERMS = 4'd12;
  localparam logic [5:0]  DIV_STEPS = 6'd32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NEST,
    S_NCOR,
    S_HMUL,
    S_HREC,
    S_HCOR,
    S_USET,
    S_DSET,
    S_DIVZ,
    S_WGT,
    S_EMIT,
    S_FINAL
  } ltsi_state_t;

  typedef struct packed {
    logic        start;
    logic [61:0] num;
    logic [39:0] den;
  } ltsi_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [39:0] rem;
  } ltsi_div_rsp_t;

  // Reciprocal floor(2^32 / i) for the Horner divisors two through twelve.
  function automatic logic [31:0] ltsi_recip(input logic [3:0] i);
    logic [31:0] r;
    case (i)
      4'd2:    r = 32'd2147483648;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741824;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870912;
      4'd9:    r = 32'd477218588;
      4'd10:   r = 32'd429496729;
      4'd11:   r = 32'd390451572;
      4'd12:   r = 32'd357913941;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

### hdl/ltsi_mul.sv
// Shared 32 by 32 bit multiplier with a registered product.
module ltsi_mul import ltsi_pkg::*; (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= {32'b0, a} * {32'b0, b};
  end

endmodule

### hdl/ltsi_div.sv
// Shared restoring divider, one quotient bit per cycle, 32 quotient bits.
module ltsi_div import ltsi_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  ltsi_div_req_t req,
  output ltsi_div_rsp_t rsp
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [39:0] rem_r;
  logic [31:0] numlo_r;
  logic [31:0] quo_r;
  logic [39:0] den_r;
  logic [40:0] trial;
  logic        qbit;

  assign trial = {rem_r, numlo_r[31]};
  assign qbit  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r  <= 1'b1;
        cnt_r   <= DIV_STEPS;
        rem_r   <= {10'b0, req.num[61:32]};
        numlo_r <= req.num[31:0];
        quo_r   <= '0;
        den_r   <= req.den;
      end else if (busy_r) begin
        rem_r   <= qbit ? 40'(trial - {1'b0, den_r}) : trial[39:0];
        numlo_r <= {numlo_r[30:0], 1'b0};
        quo_r   <= {quo_r[30:0], qbit};
        cnt_r   <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

### hdl/logodds_to_simplex_inverse_top.sv
// Top level of the stick-breaking simplex transform with its sequencer.
//
// Input channel: one coordinate (signed Q8.24) per item on in_coord_value,
// taken when in_valid is high and in_stall is low. A vector takes
// SIMPLEX_SIZE-1 items. Output channel: one weight (unsigned Q1.31) per item
// with its index; the last item of a vector also yields the leftover stick
// with out_vector_end set, so it gives two output items.
// One item is in work at a time and in_stall is high while it is.
// When the stick is used up an item goes straight to output with a floored
// weight of one LSB. Otherwise it passes a reciprocal multiply and one
// correction step for the range reduction, twelve Horner steps (multiply,
// reciprocal multiply, correction) on the shared multiplier, setup states and
// one 32-step pass of the shared divider for the final reciprocal.
// Results sit in an output register; the next item is accepted while a
// result waits there. When the receiver stalls, the sequencer holds its
// result until the register frees up. Reset starts a new vector with a
// full stick and clears out_valid.
module logodds_to_simplex_inverse_top import ltsi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_coord_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_weight,
  output logic [7:0]  out_weight_index,
  output logic        out_vector_end,
  output logic        out_floor_applied
);

  ltsi_state_t state_r, state_nxt;
  logic signed [32:0] stick_r, stick_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  m_r, m_nxt;
  logic        yneg_r, yneg_nxt;
  logic [31:0] a_r, a_nxt;
  logic [7:0]  n_r, n_nxt;
  logic [29:0] r_r, r_nxt;
  logic [30:0] p_r, p_nxt;
  logic [3:0]  term_r, term_nxt;
  logic [29:0] t_r, t_nxt;
  logic [30:0] u_r, u_nxt;
  logic [31:0] w_r, w_nxt;
  logic        flr_r, flr_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_weight_r, out_weight_nxt;
  logic [7:0]  out_index_r, out_index_nxt;
  logic        out_end_r, out_end_nxt;
  logic        out_floor_r, out_floor_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  ltsi_div_req_t div_req;
  ltsi_div_rsp_t div_rsp;

  logic        out_free;
  logic [32:0] y_abs;
  logic [37:0] r_full;
  logic [29:0] q0, q;
  logic [33:0] prodi, remi;
  logic [30:0] u_c;
  logic [39:0] den_c;
  logic [63:0] wsum;

  ltsi_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  ltsi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stick_r     <= ONE_Q31;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stick_r     <= stick_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r          <= m_nxt;
    yneg_r       <= yneg_nxt;
    a_r          <= a_nxt;
    n_r          <= n_nxt;
    r_r          <= r_nxt;
    p_r          <= p_nxt;
    term_r       <= term_nxt;
    t_r          <= t_nxt;
    u_r          <= u_nxt;
    w_r          <= w_nxt;
    flr_r        <= flr_nxt;
    out_weight_r <= out_weight_nxt;
    out_index_r  <= out_index_nxt;
    out_end_r    <= out_end_nxt;
    out_floor_r  <= out_floor_nxt;
  end

  assign out_free = !out_valid_r || !out_stall;
  assign y_abs    = in_coord_value[31] ? (33'd0 - {1'b1, in_coord_value})
                                       : {1'b0, in_coord_value};
  assign r_full   = {a_r, 6'b0} - mul_p[37:0];
  assign q0       = (term_r == 4'd1) ? t_r : mul_p[61:32];
  assign prodi    = {4'b0, q0} * {30'b0, term_r};
  assign remi     = {4'b0, t_r} - prodi;
  assign q        = (remi >= {30'b0, term_r}) ? 30'(q0 + 30'd1) : q0;
  assign u_c      = (n_r >= 8'd31) ? 31'd0 : (p_r >> n_r);
  assign den_c    = yneg_r ? ({9'b0, u_r} + {2'b0, m_r, 30'b0})
                           : ({9'b0, ONE_Q30} + mul_p[39:0]);
  assign wsum     = mul_p + {33'b0, ONE_Q30};

  always_comb begin
    state_nxt      = state_r;
    stick_nxt      = stick_r;
    pos_nxt        = pos_r;
    m_nxt          = m_r;
    yneg_nxt       = yneg_r;
    a_nxt          = a_r;
    n_nxt          = n_r;
    r_nxt          = r_r;
    p_nxt          = p_r;
    term_nxt       = term_r;
    t_nxt          = t_r;
    u_nxt          = u_r;
    w_nxt          = w_r;
    flr_nxt        = flr_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_weight_nxt = out_weight_r;
    out_index_nxt  = out_index_r;
    out_end_nxt    = out_end_r;
    out_floor_nxt  = out_floor_r;
    mul_a          = '0;
    mul_b          = '0;
    div_req.start  = 1'b0;
    div_req.num    = '0;
    div_req.den    = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          yneg_nxt = in_coord_value[31];
          m_nxt    = M_TOP - pos_r;
          if (stick_r <= 33'sd0) begin
            w_nxt     = 32'd1;
            flr_nxt   = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            a_nxt     = y_abs[31:0];
            mul_a     = y_abs[31:0];
            mul_b     = {15'b0, INV_LN2_Q46};
            state_nxt = S_NEST;
          end
        end
      end
      S_NEST: begin
        n_nxt     = mul_p[47:40];
        mul_a     = {24'b0, mul_p[47:40]};
        mul_b     = LN2_Q30[31:0];
        state_nxt = S_NCOR;
      end
      S_NCOR: begin
        if (r_full >= LN2_Q30[37:0]) begin
          n_nxt = n_r + 8'd1;
          r_nxt = 30'(r_full - LN2_Q30[37:0]);
        end else begin
          r_nxt = r_full[29:0];
        end
        p_nxt     = ONE_Q30;
        term_nxt  = EXP_TERMS;
        state_nxt = S_HMUL;
      end
      S_HMUL: begin
        mul_a     = {2'b0, r_r};
        mul_b     = {1'b0, p_r};
        state_nxt = S_HREC;
      end
      S_HREC: begin
        t_nxt     = mul_p[59:30];
        mul_a     = {2'b0, mul_p[59:30]};
        mul_b     = ltsi_recip(term_r);
        state_nxt = S_HCOR;
      end
      S_HCOR: begin
        p_nxt = ONE_Q30 - {1'b0, q};
        if (term_r == 4'd1) begin
          state_nxt = S_USET;
        end else begin
          term_nxt  = term_r - 4'd1;
          state_nxt = S_HMUL;
        end
      end
      S_USET: begin
        u_nxt     = u_c;
        mul_a     = {24'b0, m_r};
        mul_b     = {1'b0, u_c};
        state_nxt = S_DSET;
      end
      S_DSET: begin
        div_req.start = 1'b1;
        div_req.den   = den_c;
        div_req.num   = yneg_r ? ({u_r, 31'b0} + {23'b0, den_c[39:1]})
                               : ({1'b1, 61'b0} + {23'b0, den_c[39:1]});
        state_nxt     = S_DIVZ;
      end
      S_DIVZ: begin
        if (div_rsp.done) begin
          mul_a     = stick_r[31:0];
          mul_b     = div_rsp.quo;
          state_nxt = S_WGT;
        end
      end
      S_WGT: begin
        w_nxt     = wsum[62:31];
        flr_nxt   = 1'b0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_weight_nxt = w_r;
          out_index_nxt  = pos_r;
          out_end_nxt    = 1'b0;
          out_floor_nxt  = flr_r;
          stick_nxt      = stick_r - $signed({1'b0, w_r});
          if (pos_r < LAST_POS) begin
            pos_nxt   = pos_r + 8'd1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_FINAL;
          end
        end
      end
      S_FINAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = pos_r + 8'd1;
          out_end_nxt   = 1'b1;
          if (stick_r < 33'sd0) begin
            out_weight_nxt = '0;
            out_floor_nxt  = 1'b1;
          end else begin
            out_weight_nxt = stick_r[31:0];
            out_floor_nxt  = 1'b0;
          end
          stick_nxt = ONE_Q31;
          pos_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_weight        = out_weight_r;
  assign out_weight_index  = out_index_r;
  assign out_vector_end    = out_end_r;
  assign out_floor_applied = out_floor_r;

`ifndef SYNTHESIS
  a_end_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_vector_end) |-> (out_weight_index == M_TOP))
    else $error("final weight carries the wrong index");

  a_floor_lsb: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_vector_end && out_floor_applied) |-> (out_weight == 32'd1))
    else $error("floored weight is not one LSB");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_weight <= 32'h8000_0000))
    else $error("weight above one");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS)
    else $error("element position beyond the vector");
`endif

endmodule
